// ===== sv/crs_pkg.sv =====
// Shared types and constants for the clip rectangle stack.
// Used by the front, back and top-level modules; depends on nothing.
package crs_pkg;

  localparam int unsigned CoordW            = 16;
  localparam int unsigned SizeW             = 15;
  localparam int unsigned DepthW            = 5;
  localparam int unsigned CfgIdxW           = 2;
  localparam int unsigned CfgDataW          = 16;
  localparam int unsigned DefaultStackDepth = 16;

  localparam logic [SizeW-1:0] DispWidthRst  = 15'd640;
  localparam logic [SizeW-1:0] DispHeightRst = 15'd480;

  // Request codes; the unused code changes no state in the back end but still yields a result.
  typedef enum logic [1:0] {
    REQ_PUSH  = 2'd0,
    REQ_POP   = 2'd1,
    REQ_CLEAR = 2'd2
  } req_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_OFFSET_X = 2'd0,
    CFG_OFFSET_Y = 2'd1,
    CFG_DISP_W   = 2'd2,
    CFG_DISP_H   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic [SizeW-1:0]         w;
    logic [SizeW-1:0]         h;
  } rect_t;

  // Classified request, as it travels from front to back.
  typedef struct packed {
    req_e  req;
    rect_t rect;
  } item_t;

  // Result beat.
  typedef struct packed {
    rect_t             clip;
    logic [DepthW-1:0] depth;
    logic              updated;
    logic              overflow;
  } result_t;

endpackage

// ===== sv/crs_fifo.sv =====
// Two-entry queue used between front and back and on the result side.
// Generic in payload width; depends on nothing else.
module crs_fifo #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  output logic             full_o,
  input  logic [Width-1:0] wr_data_i,
  output logic             empty_o,
  input  logic             pop_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] slot_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       fill_q, fill_d;
  logic             do_wr, do_rd;

  assign full_o    = fill_q[1];
  assign empty_o   = (fill_q == 2'd0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = pop_i && !empty_o;
  assign rd_data_o = slot_q[rd_ptr_q];

  // Track occupancy.
  always_comb begin
    fill_d = fill_q;
    if (do_wr && !do_rd) begin
      fill_d = fill_q + 2'd1;
    end else if (do_rd && !do_wr) begin
      fill_d = fill_q - 2'd1;
    end
  end

  // Advance pointers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      fill_q <= fill_d;
      if (do_wr) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_rd) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  // Hold payload.
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slot_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// ===== sv/crs_front.sv =====
// Front end: accepts requests, classifies them and applies the offset.
// Depends on crs_pkg.
module crs_front (
  input  logic                              push_i,
  output logic                              full_o,
  input  logic [1:0]                        req_type_i,
  input  logic signed [crs_pkg::CoordW-1:0] rect_x_i,
  input  logic signed [crs_pkg::CoordW-1:0] rect_y_i,
  input  logic [crs_pkg::SizeW-1:0]         rect_w_i,
  input  logic [crs_pkg::SizeW-1:0]         rect_h_i,
  input  logic signed [crs_pkg::CoordW-1:0] offset_x_i,
  input  logic signed [crs_pkg::CoordW-1:0] offset_y_i,
  input  logic                              q_full_i,
  output logic                              q_wr_o,
  output crs_pkg::item_t                    q_item_o
);
  import crs_pkg::*;

  // Add two coordinates and saturate to the coordinate range.
  function automatic logic signed [CoordW-1:0] sat_add(
    input logic signed [CoordW-1:0] a,
    input logic signed [CoordW-1:0] b
  );
    logic signed [CoordW:0] sum;
    sum = (CoordW+1)'(a) + (CoordW+1)'(b);
    if (sum[CoordW] != sum[CoordW-1]) begin
      sat_add = sum[CoordW] ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}};
    end else begin
      sat_add = sum[CoordW-1:0];
    end
  endfunction

  // Stall on a full queue.
  assign full_o = q_full_i;
  assign q_wr_o = push_i && !q_full_i;

  // Classify and move the rectangle.
  always_comb begin
    q_item_o.req    = req_e'(req_type_i);
    q_item_o.rect.x = sat_add(rect_x_i, offset_x_i);
    q_item_o.rect.y = sat_add(rect_y_i, offset_y_i);
    q_item_o.rect.w = rect_w_i;
    q_item_o.rect.h = rect_h_i;
  end

endmodule

// ===== sv/crs_back.sv =====
// Back end: executes requests against the rectangle stack and current clip.
// Depends on crs_pkg; the stack store is a memory inside this module.
module crs_back #(
  parameter int unsigned StackDepth = crs_pkg::DefaultStackDepth
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_empty_i,
  output logic                      q_pop_o,
  input  crs_pkg::item_t            q_item_i,
  input  logic [crs_pkg::SizeW-1:0] disp_w_i,
  input  logic [crs_pkg::SizeW-1:0] disp_h_i,
  input  logic                      r_full_i,
  output logic                      r_wr_o,
  output crs_pkg::result_t          r_data_o
);
  import crs_pkg::*;

  localparam int unsigned AddrW = $clog2(StackDepth);
  localparam int unsigned CntW  = $clog2(StackDepth + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(StackDepth);

  rect_t                  store_mem [StackDepth];
  rect_t                  below_q;
  rect_t                  cur_q, cur_d, isect;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [AddrW-1:0]       wr_addr, rd_addr;
  logic                   go, wr_en, upd, ovf, no_overlap;
  logic signed [CoordW-1:0] lft, top;
  logic signed [CoordW:0] cur_r, cur_b, mv_r, mv_b, rgt, bot, lft_x, top_x, dif_w, dif_h;

  // Intersect the moved rectangle with the current clip.
  always_comb begin
    cur_r = (CoordW+1)'(cur_q.x) + $signed({2'b00, cur_q.w});
    cur_b = (CoordW+1)'(cur_q.y) + $signed({2'b00, cur_q.h});
    mv_r  = (CoordW+1)'(q_item_i.rect.x) + $signed({2'b00, q_item_i.rect.w});
    mv_b  = (CoordW+1)'(q_item_i.rect.y) + $signed({2'b00, q_item_i.rect.h});
    lft   = (cur_q.x > q_item_i.rect.x) ? cur_q.x : q_item_i.rect.x;
    top   = (cur_q.y > q_item_i.rect.y) ? cur_q.y : q_item_i.rect.y;
    rgt   = (cur_r < mv_r) ? cur_r : mv_r;
    bot   = (cur_b < mv_b) ? cur_b : mv_b;
    lft_x = (CoordW+1)'(lft);
    top_x = (CoordW+1)'(top);
    dif_w = rgt - lft_x;
    dif_h = bot - top_x;
    no_overlap = (lft_x > rgt) || (bot < top_x);
    if (no_overlap) begin
      isect = '0;
    end else begin
      isect.x = lft;
      isect.y = top;
      isect.w = dif_w[SizeW-1:0];
      isect.h = dif_h[SizeW-1:0];
    end
  end

  // Execute one request when a result slot is free.
  always_comb begin
    go    = !q_empty_i && !r_full_i;
    cnt_d = cnt_q;
    cur_d = cur_q;
    wr_en = 1'b0;
    upd   = 1'b0;
    ovf   = 1'b0;
    if (go) begin
      unique case (q_item_i.req)
        REQ_PUSH: begin
          if (cnt_q == CntMax) begin
            ovf = 1'b1;
          end else begin
            wr_en = 1'b1;
            upd   = 1'b1;
            cnt_d = cnt_q + CntW'(1);
            cur_d = (cnt_q == '0) ? q_item_i.rect : isect;
          end
        end
        REQ_POP: begin
          if (cnt_q != '0) begin
            cnt_d = cnt_q - CntW'(1);
            if (cnt_q != CntW'(1)) begin
              cur_d = below_q;
              upd   = 1'b1;
            end
          end
        end
        REQ_CLEAR: begin
          cnt_d   = '0;
          cur_d.x = '0;
          cur_d.y = '0;
          cur_d.w = disp_w_i;
          cur_d.h = disp_h_i;
          upd     = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign q_pop_o  = go;
  assign r_wr_o   = go;
  assign r_data_o = '{clip: cur_d, depth: DepthW'(cnt_d), updated: upd, overflow: ovf};

  // Push writes the new top; the entry below the next top is prefetched.
  assign wr_addr = cnt_q[AddrW-1:0];
  assign rd_addr = AddrW'(cnt_d - CntW'(2));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_mem[wr_addr] <= cur_d;
    end
    below_q <= store_mem[rd_addr];
  end

  // Hold count and current clip.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      cur_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      cur_q <= cur_d;
    end
  end

endmodule

// ===== sv/clip_rect_stack_core.sv =====
// Top level of the clip rectangle stack: configuration registers, front,
// queues and back. Depends on crs_pkg, crs_front, crs_fifo and crs_back.
//
//   channel  handshake           beat accepted when   payload
//   request  push / full         push && !full        req_type_i, rect_*_i
//   result   empty / pop         pop && !empty        clip_*_o, stack_depth_o, flags
//   config   cfg_we_i            cfg_we_i             cfg_idx_i, cfg_wdata_i
//
// One request per cycle is sustained unless the result side backs up; the stack
// update and intersection happen in the back end.
// A result passes through the middle queue and the result queue, both
// registered, before it reaches the result ports.
// The stack store is not cleared by reset; only the count and clip are.
// Each side has a two-entry queue, so a stalled result side backs up into
// full only after both queues fill.
module clip_rect_stack_core #(
  parameter int unsigned StackDepth = crs_pkg::DefaultStackDepth
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push,
  output logic                                 full,
  input  logic [1:0]                           req_type_i,
  input  logic signed [crs_pkg::CoordW-1:0]    rect_x_i,
  input  logic signed [crs_pkg::CoordW-1:0]    rect_y_i,
  input  logic [crs_pkg::SizeW-1:0]            rect_w_i,
  input  logic [crs_pkg::SizeW-1:0]            rect_h_i,
  output logic                                 empty,
  input  logic                                 pop,
  output logic signed [crs_pkg::CoordW-1:0]    clip_x_o,
  output logic signed [crs_pkg::CoordW-1:0]    clip_y_o,
  output logic [crs_pkg::SizeW-1:0]            clip_w_o,
  output logic [crs_pkg::SizeW-1:0]            clip_h_o,
  output logic [crs_pkg::DepthW-1:0]           stack_depth_o,
  output logic                                 clip_updated_o,
  output logic                                 overflow_o,
  input  logic                                 cfg_we_i,
  input  logic [crs_pkg::CfgIdxW-1:0]          cfg_idx_i,
  input  logic [crs_pkg::CfgDataW-1:0]         cfg_wdata_i
);
  import crs_pkg::*;

  logic signed [CoordW-1:0] offset_x_q, offset_y_q;
  logic [SizeW-1:0]         disp_w_q, disp_h_q;

  logic    mid_wr, mid_full, mid_empty, mid_pop;
  item_t   mid_wdata, mid_rdata;
  logic    res_wr, res_full;
  result_t res_wdata, res_rdata;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_x_q <= '0;
      offset_y_q <= '0;
      disp_w_q   <= DispWidthRst;
      disp_h_q   <= DispHeightRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_OFFSET_X: offset_x_q <= cfg_wdata_i;
        CFG_OFFSET_Y: offset_y_q <= cfg_wdata_i;
        CFG_DISP_W:   disp_w_q   <= cfg_wdata_i[SizeW-1:0];
        CFG_DISP_H:   disp_h_q   <= cfg_wdata_i[SizeW-1:0];
        default: begin
        end
      endcase
    end
  end

  crs_front u_front (
    .push_i     (push),
    .full_o     (full),
    .req_type_i (req_type_i),
    .rect_x_i   (rect_x_i),
    .rect_y_i   (rect_y_i),
    .rect_w_i   (rect_w_i),
    .rect_h_i   (rect_h_i),
    .offset_x_i (offset_x_q),
    .offset_y_i (offset_y_q),
    .q_full_i   (mid_full),
    .q_wr_o     (mid_wr),
    .q_item_o   (mid_wdata)
  );

  crs_fifo #(
    .Width ($bits(item_t))
  ) u_mid_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (mid_wr),
    .full_o    (mid_full),
    .wr_data_i (mid_wdata),
    .empty_o   (mid_empty),
    .pop_i     (mid_pop),
    .rd_data_o (mid_rdata)
  );

  crs_back #(
    .StackDepth (StackDepth)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (mid_empty),
    .q_pop_o   (mid_pop),
    .q_item_i  (mid_rdata),
    .disp_w_i  (disp_w_q),
    .disp_h_i  (disp_h_q),
    .r_full_i  (res_full),
    .r_wr_o    (res_wr),
    .r_data_o  (res_wdata)
  );

  crs_fifo #(
    .Width ($bits(result_t))
  ) u_res_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (res_wr),
    .full_o    (res_full),
    .wr_data_i (res_wdata),
    .empty_o   (empty),
    .pop_i     (pop),
    .rd_data_o (res_rdata)
  );

  // Unpack the result beat.
  assign clip_x_o       = res_rdata.clip.x;
  assign clip_y_o       = res_rdata.clip.y;
  assign clip_w_o       = res_rdata.clip.w;
  assign clip_h_o       = res_rdata.clip.h;
  assign stack_depth_o  = res_rdata.depth;
  assign clip_updated_o = res_rdata.updated;
  assign overflow_o     = res_rdata.overflow;

  // A dropped push never updates the clip.
  a_ovf_no_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && overflow_o) |-> !clip_updated_o)
    else $error("overflow result reports a clip update");

  // A dropped push only happens on a full stack.
  a_ovf_full_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && overflow_o) |-> (stack_depth_o == DepthW'(StackDepth)))
    else $error("overflow result without a full stack");

  // An update that leaves the stack empty is a clear, anchored at the origin.
  a_clear_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (StackDepth < 32 && !empty && clip_updated_o && stack_depth_o == '0)
      |-> (clip_x_o == '0 && clip_y_o == '0))
    else $error("empty-stack update not at origin");

  // The back end drains the middle queue whenever the result side has room.
  a_back_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!mid_empty && !res_full) |-> (mid_pop && res_wr))
    else $error("back end stalled with room on both sides");

endmodule
